// File: hdl/clnb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_pkg
// Shared types and codes for the character display nibble bus controller.
// ----------------------------------------------------------------------------
package clnb_pkg;

   // request commands
   localparam logic [2:0] CMD_WRITE_INSTR = 3'd0;
   localparam logic [2:0] CMD_WRITE_DATA  = 3'd1;
   localparam logic [2:0] CMD_SET_CURSOR  = 3'd2;
   localparam logic [2:0] CMD_RAW_INSTR   = 3'd3;
   localparam logic [2:0] CMD_BUS_NIBBLE  = 3'd4;

   // result actions
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_DONE  = 2'd2;

   // done status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   // queued job kinds
   localparam logic [1:0] JOB_READS = 2'd0;
   localparam logic [1:0] JOB_WRITE = 2'd1;
   localparam logic [1:0] JOB_DONE  = 2'd2;

   // register map
   localparam int          CSR_ADDR_WIDTH     = 3;
   localparam int          CSR_DATA_WIDTH     = 32;
   localparam logic [7:0]  POLL_LIMIT_RESET   = 8'd100;
   localparam logic        CSR_IDX_POLL_LIMIT = 1'b0;

   // cursor addressing
   localparam logic [7:0]  CURSOR_BASE  = 8'h80;
   localparam logic [7:0]  CURSOR_LINE2 = 8'h40;

   localparam int          JOB_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_val;
      logic       sel;
      logic [1:0] status;
   } job_type;

   typedef struct packed {
      logic [1:0] action;
      logic       reg_select;
      logic       read_not_write;
      logic [3:0] out_nibble;
      logic [1:0] status;
      logic       last;
   } result_type;

endpackage

// File: hdl/clnb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb request and result channels
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface clnb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] byte_value;
   logic       line;
   logic [5:0] column;
   logic [3:0] bus_nibble;

   modport source (output valid, command, byte_value, line, column, bus_nibble,
                   input ready);
   modport sink   (input valid, command, byte_value, line, column, bus_nibble,
                   output ready);
endinterface

interface clnb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       reg_select;
   logic       read_not_write;
   logic [3:0] out_nibble;
   logic [1:0] status;
   logic       last;

   modport source (output valid, action, reg_select, read_not_write, out_nibble,
                   status, last, input ready);
   modport sink   (input valid, action, reg_select, read_not_write, out_nibble,
                   status, last, output ready);
endinterface

// File: hdl/clnb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_front
// Accepts requests and bus nibbles, tracks the busy poll, queues jobs.
// ----------------------------------------------------------------------------
module clnb_front (
   input  logic              clock,
   input  logic              reset,
   clnb_req_if.sink          req_ch,
   input  logic [7:0]        poll_limit,
   input  logic              queue_full,
   output logic              job_push,
   output clnb_pkg::job_type job_data
);
   import clnb_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] pending_byte_ff, pending_byte_in;
   logic       pending_sel_ff, pending_sel_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [7:0] polls_left_ff, polls_left_in;
   logic       accept;
   logic       busy;
   logic [7:0] cursor_addr;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign busy         = (phase_ff == PH_HIGH) || (phase_ff == PH_LOW);
   assign cursor_addr  = CURSOR_BASE | (req_ch.line ? CURSOR_LINE2 : 8'h00)
                         | {2'b00, req_ch.column};

   always_comb begin
      phase_in          = phase_ff;
      pending_byte_in   = pending_byte_ff;
      pending_sel_in    = pending_sel_ff;
      high_nibble_in    = high_nibble_ff;
      polls_left_in     = polls_left_ff;
      job_push          = 1'b0;
      job_data.kind     = JOB_DONE;
      job_data.byte_val = 8'h00;
      job_data.sel      = 1'b0;
      job_data.status   = ST_REFUSED;
      if (accept) begin
         job_push = 1'b1;
         if (req_ch.command > CMD_BUS_NIBBLE) begin
            job_data.kind = JOB_DONE;
         end else if (req_ch.command == CMD_BUS_NIBBLE) begin
            if (!busy) begin
               job_data.kind = JOB_DONE;
            end else if (phase_ff == PH_HIGH) begin
               // first status nibble: keep it, nothing to emit
               high_nibble_in = req_ch.bus_nibble;
               phase_in       = PH_LOW;
               job_push       = 1'b0;
            end else if (!high_nibble_ff[3]) begin
               job_data.kind     = JOB_WRITE;
               job_data.byte_val = pending_byte_ff;
               job_data.sel      = pending_sel_ff;
               job_data.status   = ST_OK;
               phase_in          = PH_IDLE;
            end else if (polls_left_ff <= 8'd1) begin
               job_data.kind   = JOB_DONE;
               job_data.status = ST_TIMEOUT;
               polls_left_in   = 8'd0;
               phase_in        = PH_IDLE;
            end else begin
               job_data.kind = JOB_READS;
               polls_left_in = polls_left_ff - 8'd1;
               phase_in      = PH_HIGH;
            end
         end else if (busy) begin
            job_data.kind = JOB_DONE;
         end else if (req_ch.command == CMD_RAW_INSTR) begin
            job_data.kind     = JOB_WRITE;
            job_data.byte_val = req_ch.byte_value;
            job_data.sel      = 1'b0;
            job_data.status   = ST_OK;
            phase_in          = PH_IDLE;
         end else begin
            if (req_ch.command == CMD_SET_CURSOR) begin
               pending_byte_in = cursor_addr;
               pending_sel_in  = 1'b0;
            end else begin
               pending_byte_in = req_ch.byte_value;
               pending_sel_in  = (req_ch.command == CMD_WRITE_DATA);
            end
            polls_left_in = poll_limit;
            phase_in      = PH_HIGH;
            job_data.kind = JOB_READS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pending_byte_ff <= 8'h00;
         pending_sel_ff  <= 1'b0;
         high_nibble_ff  <= 4'h0;
         polls_left_ff   <= 8'h00;
      end else begin
         phase_ff        <= phase_in;
         pending_byte_ff <= pending_byte_in;
         pending_sel_ff  <= pending_sel_in;
         high_nibble_ff  <= high_nibble_in;
         polls_left_ff   <= polls_left_in;
      end
   end

endmodule

// File: hdl/clnb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module clnb_queue #(
   parameter int DEPTH = clnb_pkg::JOB_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clnb_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output clnb_pkg::job_type head_data
);
   import clnb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/clnb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_back
// Expands queued jobs into bus strobes and done results.
// ----------------------------------------------------------------------------
module clnb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  clnb_pkg::job_type head_data,
   output logic              pop,
   clnb_rsp_if.source        rsp_ch
);
   import clnb_pkg::*;

   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type res;
   logic       load;

   always_comb begin
      res.action         = ACT_DONE;
      res.reg_select     = 1'b0;
      res.read_not_write = 1'b0;
      res.out_nibble     = 4'h0;
      res.status         = head_data.status;
      res.last           = 1'b1;
      case (head_data.kind)
         JOB_READS: begin
            res.action         = ACT_READ;
            res.read_not_write = 1'b1;
            res.status         = ST_OK;
            res.last           = (step_ff == 2'd1);
         end
         JOB_WRITE: begin
            if (step_ff == 2'd0) begin
               res.action     = ACT_WRITE;
               res.reg_select = head_data.sel;
               res.out_nibble = head_data.byte_val[7:4];
               res.status     = ST_OK;
               res.last       = 1'b0;
            end else if (step_ff == 2'd1) begin
               res.action     = ACT_WRITE;
               res.reg_select = head_data.sel;
               res.out_nibble = head_data.byte_val[3:0];
               res.status     = ST_OK;
               res.last       = 1'b0;
            end else begin
               res.status = ST_OK;
            end
         end
         default: begin
            res.action = ACT_DONE;
         end
      endcase
   end

   assign load = head_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = load && res.last;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         step_in      = res.last ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.action         = rsp_ff.action;
   assign rsp_ch.reg_select     = rsp_ff.reg_select;
   assign rsp_ch.read_not_write = rsp_ff.read_not_write;
   assign rsp_ch.out_nibble     = rsp_ff.out_nibble;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.last           = rsp_ff.last;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd3)
      else $error("back step counter out of range");

   a_reads_two_steps: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_data.kind == JOB_READS) |-> step_ff != 2'd2)
      else $error("read job ran past its second strobe");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result pending right after reset");

   a_step_clears_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> step_ff == 2'd0)
      else $error("step not cleared after finishing a job");

endmodule

// File: hdl/char_lcd_nibble_bus_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_controller
// 4-bit character display bus controller with busy-flag polling.
// ----------------------------------------------------------------------------
// path: the first result of a transaction is written into the job queue on
//   the accepting edge and then loaded into the output register, where it
//   can be taken; a stall on the result port holds it in the queue
// throughput: one request per cycle while the job queue has room; up to 3
//   results per job leave at one per cycle while the result port is ready
// reset: synchronous, active high; clears poll phase, queue and output
//   valid flag, poll_limit returns to 100
module char_lcd_nibble_bus_controller #(
   parameter int QUEUE_DEPTH = clnb_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   clnb_req_if.sink                            req_ch,
   clnb_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [clnb_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [clnb_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [clnb_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import clnb_pkg::*;

   // configuration register
   logic [7:0] poll_limit_ff, poll_limit_in;
   logic       csr_write;
   logic       csr_hit;

   // front to queue, queue to back
   logic    job_push;
   job_type job_data;
   logic    queue_full;
   logic    head_valid;
   job_type head_data;
   logic    job_pop;

   // apb: zero wait states, write lands on the access phase
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_POLL_LIMIT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_comb begin
      poll_limit_in = poll_limit_ff;
      if (csr_write) begin
         poll_limit_in = pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, poll_limit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
      end else begin
         poll_limit_ff <= poll_limit_in;
      end
   end

   // front: classifies each transaction and owns the poll state
   clnb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .poll_limit (poll_limit_ff),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_data)
   );

   // queue decouples request acceptance from result delivery
   clnb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back: one result per cycle into a registered output, unless the result port stalls
   clnb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (job_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: test/tb_char_lcd_nibble_bus_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_bus_controller
// Self-checking bench for the 4-bit display bus controller. Request and
// returned-nibble transactions go in over a valid/ready channel with bursty
// timing. Every result is checked field by field against typed-in rows or an
// in-bench model of the busy-flag poll. A directed table comes first, then
// well-formed write/poll sequences mixed with noise under several poll_limit settings.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_bus_controller;
   import clnb_pkg::*;

   // poll phase codes of the bench model
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_STAT_HI = 2'd1;
   localparam logic [1:0] PH_STAT_LO = 2'd2;

   // unknown command codes, all refused
   localparam logic [2:0] CMD_BAD_LO  = 3'd5;
   localparam logic [2:0] CMD_BAD_MID = 3'd6;
   localparam logic [2:0] CMD_BAD_HI  = 3'd7;

   localparam logic [CSR_ADDR_WIDTH-1:0] POLL_LIMIT_ADDR =
      CSR_ADDR_WIDTH'(4 * CSR_IDX_POLL_LIMIT);

   localparam int RAND_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 56;
   localparam int SETTLE_CYCLES   = 4;

   typedef struct {
      logic [2:0] command;
      logic [7:0] byte_value;
      logic       line;
      logic [5:0] column;
      logic [3:0] bus_nibble;
   } req_item_type;

   // model copy of the controller state plus its register
   typedef struct {
      logic [1:0] phase;
      logic [7:0] pend_byte;
      logic       pend_sel;
      logic [3:0] stat_hi;
      logic [7:0] polls_left;
      logic [7:0] poll_limit;
   } ctl_state_type;

   // what a request transaction must produce: typed-in or from the model
   typedef struct {
      bit         typed;
      int         n;
      result_type r[3];
   } exp_desc_type;

   typedef struct {
      bit           is_cfg;
      logic [7:0]   cfg_val;
      req_item_type it;
      exp_desc_type d;
   } dir_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   clnb_req_if req_bus ();
   clnb_rsp_if rsp_bus ();

   char_lcd_nibble_bus_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ctl_state_type gen_st;       // tracks the phase for the stimulus generator
   ctl_state_type mon_st;       // advanced on each accepted request transaction
   exp_desc_type  pending_desc_q[$];
   result_type    expected_rsp_q[$];
   result_type    pred_rsp_q[$];
   result_type    scratch_q[$];
   dir_row_type   dir_rows[$];
   int            errors;
   int            burst_left;

   // ------------------------------------------------------------------------
   // bench model of the busy-flag poll
   // ------------------------------------------------------------------------
   function automatic result_type mk_result(logic [1:0] act, logic rs, logic rnw,
                                            logic [3:0] nib, logic [1:0] st,
                                            logic lst);
      result_type r;
      r.action         = act;
      r.reg_select     = rs;
      r.read_not_write = rnw;
      r.out_nibble     = nib;
      r.status         = st;
      r.last           = lst;
      return r;
   endfunction

   // two read strobes, then wait for the high status nibble
   function automatic void push_status_reads(ref ctl_state_type s, ref result_type q[$]);
      q.push_back(mk_result(ACT_READ, 1'b0, 1'b1, 4'h0, ST_OK, 1'b0));
      q.push_back(mk_result(ACT_READ, 1'b0, 1'b1, 4'h0, ST_OK, 1'b0));
      s.phase = PH_STAT_HI;
   endfunction

   // high nibble, low nibble, done
   function automatic void push_byte_write(ref ctl_state_type s, ref result_type q[$],
                                           input logic [7:0] b, input logic sel);
      q.push_back(mk_result(ACT_WRITE, sel, 1'b0, b[7:4], ST_OK, 1'b0));
      q.push_back(mk_result(ACT_WRITE, sel, 1'b0, b[3:0], ST_OK, 1'b0));
      q.push_back(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_OK, 1'b0));
      s.phase = PH_IDLE;
   endfunction

   function automatic void predict_bus_transfer(ref ctl_state_type s,
                                                input req_item_type it,
                                                ref result_type q[$]);
      logic polling;
      polling = (s.phase == PH_STAT_HI) || (s.phase == PH_STAT_LO);
      q.delete();
      if (it.command > CMD_BUS_NIBBLE) begin
         q.push_back(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_REFUSED, 1'b0));
      end else if (it.command == CMD_BUS_NIBBLE) begin
         if (!polling) begin
            q.push_back(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_REFUSED, 1'b0));
         end else if (s.phase == PH_STAT_HI) begin
            s.stat_hi = it.bus_nibble;
            s.phase   = PH_STAT_LO;
         end else if (!s.stat_hi[3]) begin
            push_byte_write(s, q, s.pend_byte, s.pend_sel);
         end else if (s.polls_left <= 8'd1) begin
            s.polls_left = 8'd0;
            s.phase      = PH_IDLE;
            q.push_back(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_TIMEOUT, 1'b0));
         end else begin
            s.polls_left = s.polls_left - 8'd1;
            push_status_reads(s, q);
         end
      end else if (polling) begin
         q.push_back(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_REFUSED, 1'b0));
      end else if (it.command == CMD_RAW_INSTR) begin
         push_byte_write(s, q, it.byte_value, 1'b0);
      end else begin
         if (it.command == CMD_SET_CURSOR) begin
            s.pend_byte = CURSOR_BASE | (it.line ? CURSOR_LINE2 : 8'h00)
                          | {2'b00, it.column};
            s.pend_sel  = 1'b0;
         end else begin
            s.pend_byte = it.byte_value;
            s.pend_sel  = (it.command == CMD_WRITE_DATA);
         end
         s.polls_left = s.poll_limit;
         push_status_reads(s, q);
      end
      if (q.size() > 0)
         q[q.size()-1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // clock, generous run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[char_lcd_nibble_bus_controller] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: ready follows its own pattern of modes
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_pattern
      int mode;
      int mode_left;
      int tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left <= 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 96);
         end
         case (mode)
            0: begin
               rsp_bus.ready <= 1'b1;            // no stalls at all
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_bus.ready <= ($urandom_range(0, 5) == 0);   // heavy stalls
            end
            default: begin
               rsp_bus.ready <= ((tick % 8) < 5);   // regular stall window
            end
         endcase
         mode_left--;
         tick++;
      end
   end

   // ------------------------------------------------------------------------
   // checker: results against the oldest expectation, requests into the model
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                  act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_checker
      result_type   want;
      exp_desc_type d;
      req_item_type seen;
      if (!reset) begin
         // a result can never come from a request accepted at this same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result, actual action %0d status %0d", $time,
                        rsp_bus.action, rsp_bus.status);
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("action", int'(want.action), int'(rsp_bus.action));
               check_field("reg_select", int'(want.reg_select),
                           int'(rsp_bus.reg_select));
               check_field("read_not_write", int'(want.read_not_write),
                           int'(rsp_bus.read_not_write));
               check_field("out_nibble", int'(want.out_nibble),
                           int'(rsp_bus.out_nibble));
               check_field("status", int'(want.status), int'(rsp_bus.status));
               check_field("last", int'(want.last), int'(rsp_bus.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.command    = req_bus.command;
            seen.byte_value = req_bus.byte_value;
            seen.line       = req_bus.line;
            seen.column     = req_bus.column;
            seen.bus_nibble = req_bus.bus_nibble;
            predict_bus_transfer(mon_st, seen, pred_rsp_q);
            if (pending_desc_q.size() == 0) begin
               d.typed = 1'b0;
               d.n     = 0;
            end else begin
               d = pending_desc_q.pop_front();
            end
            if (d.typed) begin
               for (int k = 0; k < d.n; k++)
                  expected_rsp_q.push_back(d.r[k]);
            end else begin
               foreach (pred_rsp_q[k])
                  expected_rsp_q.push_back(pred_rsp_q[k]);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // bursts of random length with random gaps in between
   task automatic send_req(input req_item_type it, input exp_desc_type d);
      int gap;
      if (burst_left <= 0) begin
         gap        = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 50)
                                                   : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.command    <= it.command;
      req_bus.byte_value <= it.byte_value;
      req_bus.line       <= it.line;
      req_bus.column     <= it.column;
      req_bus.bus_nibble <= it.bus_nibble;
      pending_desc_q.push_back(d);
      predict_bus_transfer(gen_st, it, scratch_q);
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // stop sending until every outstanding result has been checked
   task automatic wait_results_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsp_q.size() != 0 || pending_desc_q.size() != 0)
         @(posedge clock);
   endtask

   // register write on an idle block, then read it back
   task automatic apply_poll_limit(input logic [7:0] v);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);   // a first status nibble has no result
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= POLL_LIMIT_ADDR;
      pwdata  <= CSR_DATA_WIDTH'(v);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      pwrite  <= 1'b0;                           // setup of the read-back
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== v) begin
         $display("%0t: poll_limit read-back mismatch, expected %0d, actual %0d",
                  $time, v, prdata[7:0]);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      gen_st.poll_limit = v;
      mon_st.poll_limit = v;
   endtask

   // ------------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------------
   function automatic void add_req(logic [2:0] cmd, logic [7:0] b, logic l,
                                   logic [5:0] col, logic [3:0] nib, bit typed);
      dir_row_type row;
      row.is_cfg          = 1'b0;
      row.cfg_val         = 8'h00;
      row.it.command      = cmd;
      row.it.byte_value   = b;
      row.it.line         = l;
      row.it.column       = col;
      row.it.bus_nibble   = nib;
      row.d.typed         = typed;
      row.d.n             = 0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_exp(result_type r);
      dir_rows[dir_rows.size()-1].d.r[dir_rows[dir_rows.size()-1].d.n] = r;
      dir_rows[dir_rows.size()-1].d.n++;
   endfunction

   function automatic void add_cfg(logic [7:0] v);
      dir_row_type row;
      row.is_cfg  = 1'b1;
      row.cfg_val = v;
      row.d.typed = 1'b0;
      row.d.n     = 0;
      dir_rows.push_back(row);
   endfunction

   function automatic void build_directed_rows();
      result_type refused;
      result_type rd;
      refused = mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_REFUSED, 1'b1);
      rd      = mk_result(ACT_READ, 1'b0, 1'b1, 4'h0, ST_OK, 1'b0);
      // right after reset: stray nibble and unknown commands are refused
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'hF, 1'b1);
      add_exp(refused);
      add_req(CMD_BAD_LO, 8'hFF, 1'b1, 6'd63, 4'hF, 1'b1);
      add_exp(refused);
      add_req(CMD_BAD_HI, 8'h00, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(refused);
      // raw instruction at both byte extremes, no poll
      add_req(CMD_RAW_INSTR, 8'hFF, 1'b1, 6'd63, 4'hF, 1'b1);
      add_exp(mk_result(ACT_WRITE, 1'b0, 1'b0, 4'hF, ST_OK, 1'b0));
      add_exp(mk_result(ACT_WRITE, 1'b0, 1'b0, 4'hF, ST_OK, 1'b0));
      add_exp(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_OK, 1'b1));
      add_req(CMD_RAW_INSTR, 8'h00, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(mk_result(ACT_WRITE, 1'b0, 1'b0, 4'h0, ST_OK, 1'b0));
      add_exp(mk_result(ACT_WRITE, 1'b0, 1'b0, 4'h0, ST_OK, 1'b0));
      add_exp(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_OK, 1'b1));
      // checked instruction write, poll starts
      add_req(CMD_WRITE_INSTR, 8'hA5, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(rd);
      rd.last = 1'b1;
      add_exp(rd);
      // request during a poll, then busy high nibble with no result
      add_req(CMD_WRITE_DATA, 8'h11, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(refused);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h8, 1'b1);
      add_req(CMD_BAD_MID, 8'h00, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(refused);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b0);   // busy, poll again
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h7, 1'b0);   // not busy
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'hF, 1'b0);
      // data write
      add_req(CMD_WRITE_DATA, 8'h3C, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b0);
      // cursor on the second line at the last column, then widest column
      add_req(CMD_SET_CURSOR, 8'h00, 1'b1, 6'd39, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_SET_CURSOR, 8'hFF, 1'b0, 6'd63, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h7, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'hF, 1'b0);
      // single-read limit: first busy read times out
      add_cfg(8'd1);
      add_req(CMD_WRITE_INSTR, 8'h01, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'hF, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h0, 1'b1);
      add_exp(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_TIMEOUT, 1'b1));
      // zero limit behaves as one read
      add_cfg(8'd0);
      add_req(CMD_WRITE_DATA, 8'h80, 1'b0, 6'd0, 4'h0, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'h8, 1'b0);
      add_req(CMD_BUS_NIBBLE, 8'h00, 1'b0, 6'd0, 4'hF, 1'b1);
      add_exp(mk_result(ACT_DONE, 1'b0, 1'b0, 4'h0, ST_TIMEOUT, 1'b1));
      add_cfg(8'd255);
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      req_item_type it;
      exp_desc_type rand_desc;
      logic [7:0]   limits[RAND_PHASES];
      int           r;
      errors     = 0;
      burst_left = 0;

      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_WRITE_INSTR;
      req_bus.byte_value = 8'h00;
      req_bus.line       = 1'b0;
      req_bus.column     = 6'd0;
      req_bus.bus_nibble = 4'h0;

      gen_st.phase      = PH_IDLE;
      gen_st.pend_byte  = 8'h00;
      gen_st.pend_sel   = 1'b0;
      gen_st.stat_hi    = 4'h0;
      gen_st.polls_left = 8'h00;
      gen_st.poll_limit = POLL_LIMIT_RESET;
      mon_st            = gen_st;

      rand_desc.typed = 1'b0;
      rand_desc.n     = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows at the reset value of poll_limit, then a few settings
      build_directed_rows();
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            apply_poll_limit(dir_rows[i].cfg_val);
         else
            send_req(dir_rows[i].it, dir_rows[i].d);
      end

      // random phases, each under its own poll_limit
      limits[0] = 8'd2;
      limits[1] = 8'd255;
      limits[2] = 8'd1;
      limits[3] = 8'($urandom_range(3, 12));
      limits[4] = 8'd3;
      limits[5] = POLL_LIMIT_RESET;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         apply_poll_limit(limits[ph]);
         // keep going past the quota until the open sequence closes
         for (int n = 0; n < ITEMS_PER_PHASE || gen_st.phase != PH_IDLE; n++) begin
            // one hold-off in the middle of a phase, poll possibly open
            if (ph == 1 && n == ITEMS_PER_PHASE / 2)
               wait_results_drained();
            it.byte_value = 8'($urandom_range(0, 255));
            it.line       = 1'($urandom_range(0, 1));
            it.column     = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 39))
                                                         : 6'($urandom_range(0, 63));
            it.bus_nibble = 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (r < 10) begin
               it.command = 3'($urandom_range(0, 7));       // noise, any command
            end else if (gen_st.phase == PH_STAT_HI) begin
               it.command       = CMD_BUS_NIBBLE;
               it.bus_nibble[3] = ($urandom_range(0, 99) < 40);   // busy flag
            end else if (gen_st.phase == PH_STAT_LO) begin
               it.command = CMD_BUS_NIBBLE;
            end else begin
               it.command = 3'($urandom_range(0, 3));       // new transfer
            end
            send_req(it, rand_desc);
         end
      end

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0)
         $display("[char_lcd_nibble_bus_controller] OK");
      else
         $display("[char_lcd_nibble_bus_controller] ERROR");
      $finish;
   end

endmodule
